FILE: rtl/rgb_led_fade_flash_engine_macros.svh
// ----------------------------------------------------------------------------
// RGB LED fade/flash engine assertion macros
// Concurrent property wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_FADE_FLASH_ENGINE_MACROS_SVH
`define RGB_LED_FADE_FLASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define RLFE_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rlfe assertion failed");
`define RLFE_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rlfe assertion failed");
`else
`define RLFE_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define RLFE_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/rlfe_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED fade/flash engine package
// Shared widths, codes and divider interface types.
// ----------------------------------------------------------------------------
package rlfe_pkg;

  localparam int RGB_W      = 24;
  localparam int ELAP_W     = 26;
  localparam int NUM_W      = 34;
  localparam int DEN_W      = 26;
  localparam int DAMPEN_DEF = 1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_STEADY = 3'd1,
    OP_TIMED  = 3'd2,
    OP_FLASH  = 3'd3,
    OP_FADE   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FLASH_DIV,
    S_BLEND_MUL,
    S_BLEND_ADD,
    S_BLEND_DIV,
    S_DAMP_START,
    S_DAMP_DIV,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/rlfe_div.sv
// ----------------------------------------------------------------------------
// RGB LED fade/flash engine serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlfe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rlfe_pkg::div_req_t req,
  output rlfe_pkg::div_rsp_t rsp
);
  import rlfe_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_shift = {rem_r, quo_r[NUM_W-1]};
  assign diff      = rem_shift - {1'b0, den_r};
  assign ge        = ~diff[DEN_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/rgb_led_fade_flash_engine.sv
// ----------------------------------------------------------------------------
// RGB LED fade/flash engine
// Command and 1 ms tick driven LED animation with dampened RGB duty output.
// ----------------------------------------------------------------------------
// One item is either a command (steady, timed, flash, fade) or a 1 ms tick.
// Items are handled one at a time; in_ready is high only while the sequencer
// waits for work. A command that needs no output passes through the execute
// state and back to idle. Every division (flash phase, fade step, dampen)
// runs on one shared serial divider (NUM_W = 34) that produces one quotient
// bit per cycle. An item that shows a colour runs three dampen divides, a
// fade tick three blend and three dampen divides, and a flash toggle one
// phase divide and three dampen divides. The result sits in an output
// register, so the next item is taken while a result still waits; only a
// further result waits for the output register to empty.
// ----------------------------------------------------------------------------
module rgb_led_fade_flash_engine #(
  parameter int DAMPEN = rlfe_pkg::DAMPEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rlfe_pkg::RGB_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic [rlfe_pkg::RGB_W-1:0] in_colour,
  input  logic [rlfe_pkg::RGB_W-1:0] in_dest_colour,
  input  logic [15:0]                in_duration,
  input  logic [7:0]                 in_flash_count,
  input  logic                       in_keep_on,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_red_duty,
  output logic [7:0]                 out_green_duty,
  output logic [7:0]                 out_blue_duty
);
  import rlfe_pkg::*;

  `include "rgb_led_fade_flash_engine_macros.svh"

  // configuration
  logic [RGB_W-1:0]  dflt_r;

  // item latched at accept
  logic [2:0]        op_r;
  logic [RGB_W-1:0]  col_r;
  logic [RGB_W-1:0]  dst_r;
  logic [15:0]       dur_r;
  logic [7:0]        cnt_r;
  logic              keep_r;

  // animation state
  state_t            state_r, state_nxt;
  logic              active_r, active_nxt;
  logic [ELAP_W-1:0] elap_r, elap_nxt;
  logic [ELAP_W-1:0] total_r, total_nxt;
  logic [RGB_W-1:0]  src_r, src_nxt;
  logic [RGB_W-1:0]  tgt_r, tgt_nxt;
  logic [15:0]       half_r, half_nxt;
  logic [7:0]        flashes_r, flashes_nxt;
  logic              lit_r, lit_nxt;
  logic              hold_r, hold_nxt;

  // sequencer datapath
  logic [1:0]        ch_r, ch_nxt;
  logic [RGB_W-1:0]  rgb_r, rgb_nxt;
  logic [RGB_W-1:0]  duty_r, duty_nxt;
  logic [NUM_W-1:0]  p1_r, p1_nxt;
  logic [NUM_W-1:0]  p2_r, p2_nxt;

  // output register
  logic              ovld_r, ovld_nxt;
  logic [RGB_W-1:0]  odat_r, odat_nxt;

  // decoded helpers
  logic [ELAP_W-1:0] e_new;
  logic              tick_end;
  logic [23:0]       flash_prod;
  logic [24:0]       flash_full;
  logic [7:0]        src_byte, tgt_byte, rgb_byte;
  logic              out_free;
  logic              act_flash, act_emit;
  div_req_t          dreq;
  div_rsp_t          drsp;

  rlfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ovld_r || out_ready;

  // saturating millisecond count for this tick
  assign e_new      = (elap_r == {ELAP_W{1'b1}}) ? elap_r : elap_r + 1'b1;
  assign tick_end   = (e_new >= total_r);
  assign flash_prod = {8'd0, dur_r} * {16'd0, cnt_r};
  assign flash_full = {flash_prod, 1'b0};

  always_comb begin
    case (ch_r)
      2'd0:    begin src_byte = src_r[23:16]; tgt_byte = tgt_r[23:16]; rgb_byte = rgb_r[23:16]; end
      2'd1:    begin src_byte = src_r[15:8];  tgt_byte = tgt_r[15:8];  rgb_byte = rgb_r[15:8];  end
      default: begin src_byte = src_r[7:0];   tgt_byte = tgt_r[7:0];   rgb_byte = rgb_r[7:0];   end
    endcase
  end

  // tick decisions taken in the execute cycle
  assign act_flash = active_r && !tick_end && (flashes_r != 8'd0) && (half_r != 16'd0);
  assign act_emit  = tick_end && (!hold_r || (src_r != tgt_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_STEADY, OP_TIMED: state_nxt = S_DAMP_START;
          OP_TICK: begin
            if (active_r) begin
              if (tick_end) begin
                if (act_emit) state_nxt = S_DAMP_START;
              end else if (flashes_r != 8'd0) begin
                if (act_flash) state_nxt = S_FLASH_DIV;
              end else if (src_r != tgt_r) begin
                state_nxt = S_BLEND_MUL;
              end
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FLASH_DIV: begin
        if (drsp.done) begin
          if (drsp.quotient[0] == lit_r) state_nxt = S_DAMP_START;
          else                          state_nxt = S_IDLE;
        end
      end
      S_BLEND_MUL: state_nxt = S_BLEND_ADD;
      S_BLEND_ADD: state_nxt = S_BLEND_DIV;
      S_BLEND_DIV: begin
        if (drsp.done) state_nxt = (ch_r == 2'd2) ? S_DAMP_START : S_BLEND_MUL;
      end
      S_DAMP_START: state_nxt = S_DAMP_DIV;
      S_DAMP_DIV: begin
        if (drsp.done) state_nxt = (ch_r == 2'd2) ? S_OUT_WAIT : S_DAMP_START;
      end
      S_OUT_WAIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and divider requests
  always_comb begin
    active_nxt  = active_r;
    elap_nxt    = elap_r;
    total_nxt   = total_r;
    src_nxt     = src_r;
    tgt_nxt     = tgt_r;
    half_nxt    = half_r;
    flashes_nxt = flashes_r;
    lit_nxt     = lit_r;
    hold_nxt    = hold_r;
    ch_nxt      = ch_r;
    rgb_nxt     = rgb_r;
    duty_nxt    = duty_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    ovld_nxt    = ovld_r && !out_ready;
    odat_nxt    = odat_r;
    dreq        = '0;

    case (state_r)
      S_EXEC: begin
        ch_nxt = 2'd0;
        case (op_r)
          OP_STEADY, OP_TIMED, OP_FLASH, OP_FADE: begin
            // every command restarts the animation
            src_nxt     = col_r;
            tgt_nxt     = (op_r == OP_FADE) ? dst_r : col_r;
            elap_nxt    = '0;
            active_nxt  = 1'b1;
            flashes_nxt = (op_r == OP_FLASH) ? cnt_r : 8'd0;
            hold_nxt    = (op_r == OP_STEADY) || ((op_r == OP_FADE) && keep_r);
            rgb_nxt     = col_r;
            if (op_r == OP_STEADY)     total_nxt = '0;
            else if (op_r == OP_FLASH) begin
              half_nxt  = dur_r;
              total_nxt = (flash_full > {9'd0, dur_r})
                        ? ELAP_W'(flash_full - {9'd0, dur_r}) : '0;
            end else                   total_nxt = {{(ELAP_W-16){1'b0}}, dur_r};
          end
          OP_TICK: begin
            if (active_r) begin
              elap_nxt = e_new;
              if (tick_end) begin
                rgb_nxt    = hold_r ? tgt_r : dflt_r;
                hold_nxt   = 1'b0;
                active_nxt = 1'b0;
                lit_nxt    = 1'b0;
              end else if (act_flash) begin
                dreq.start    = 1'b1;
                dreq.dividend = NUM_W'(e_new);
                dreq.divisor  = DEN_W'(half_r);
              end
            end
          end
          default: ;
        endcase
      end
      S_FLASH_DIV: begin
        // even quotient is the lit phase
        if (drsp.done && (drsp.quotient[0] == lit_r)) begin
          lit_nxt = !drsp.quotient[0];
          rgb_nxt = drsp.quotient[0] ? '0 : src_r;
        end
      end
      S_BLEND_MUL: begin
        p1_nxt = NUM_W'(src_byte * (total_r - elap_r));
        p2_nxt = NUM_W'(tgt_byte * elap_r);
      end
      S_BLEND_ADD: begin
        dreq.start    = 1'b1;
        dreq.dividend = p1_r + p2_r;
        dreq.divisor  = total_r;
      end
      S_BLEND_DIV: begin
        if (drsp.done) begin
          case (ch_r)
            2'd0:    rgb_nxt[23:16] = drsp.quotient[7:0];
            2'd1:    rgb_nxt[15:8]  = drsp.quotient[7:0];
            default: rgb_nxt[7:0]   = drsp.quotient[7:0];
          endcase
          ch_nxt = (ch_r == 2'd2) ? 2'd0 : ch_r + 1'b1;
        end
      end
      S_DAMP_START: begin
        dreq.start    = 1'b1;
        dreq.dividend = NUM_W'(rgb_byte);
        dreq.divisor  = DEN_W'(DAMPEN);
      end
      S_DAMP_DIV: begin
        if (drsp.done) begin
          case (ch_r)
            2'd0:    duty_nxt[23:16] = drsp.quotient[7:0];
            2'd1:    duty_nxt[15:8]  = drsp.quotient[7:0];
            default: duty_nxt[7:0]   = drsp.quotient[7:0];
          endcase
          ch_nxt = (ch_r == 2'd2) ? 2'd0 : ch_r + 1'b1;
        end
      end
      S_OUT_WAIT: begin
        // hand the result over once the output register is free
        if (out_free) begin
          ovld_nxt = 1'b1;
          odat_nxt = duty_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dflt_r    <= '0;
      active_r  <= 1'b0;
      elap_r    <= '0;
      total_r   <= '0;
      src_r     <= '0;
      tgt_r     <= '0;
      half_r    <= '0;
      flashes_r <= '0;
      lit_r     <= 1'b0;
      hold_r    <= 1'b0;
      ch_r      <= 2'd0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) dflt_r <= cfg_wdata;
      active_r  <= active_nxt;
      elap_r    <= elap_nxt;
      total_r   <= total_nxt;
      src_r     <= src_nxt;
      tgt_r     <= tgt_nxt;
      half_r    <= half_nxt;
      flashes_r <= flashes_nxt;
      lit_r     <= lit_nxt;
      hold_r    <= hold_nxt;
      ch_r      <= ch_nxt;
      ovld_r    <= ovld_nxt;
    end
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      col_r  <= in_colour;
      dst_r  <= in_dest_colour;
      dur_r  <= in_duration;
      cnt_r  <= in_flash_count;
      keep_r <= in_keep_on;
    end
    rgb_r  <= rgb_nxt;
    duty_r <= duty_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    odat_r <= odat_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_red_duty   = odat_r[23:16];
  assign out_green_duty = odat_r[15:8];
  assign out_blue_duty  = odat_r[7:0];

  // the divider only runs while the sequencer waits on it
  `RLFE_ASSERT_IMP(a_div_owner, clk, rst_n, drsp.busy, (state_r == S_FLASH_DIV) || (state_r == S_BLEND_DIV) || (state_r == S_DAMP_DIV))
  // flash phase is never left lit on an idle engine
  `RLFE_ASSERT_IMP(a_lit_idle, clk, rst_n, !active_r, !lit_r)
  // channel counter stays within the three colors
  `RLFE_ASSERT_IMP(a_ch_range, clk, rst_n, 1'b1, ch_r != 2'd3)
  // a pending result is never overwritten
  `RLFE_ASSERT_NXT(a_out_hold, clk, rst_n, ovld_r && !out_ready, ovld_r && (odat_r == $past(odat_r)))

endmodule
